// ===== hdl/chps_pkg.sv =====
// Package with the constants, types and helper functions of the cubic Hermite path stepper.
`timescale 1ns / 1ps
package chps_pkg;

	localparam int FRAC_BITS = 12;
	localparam int T_W       = FRAC_BITS + 1;        // t in [0, 2.0)
	localparam int W_W       = FRAC_BITS + 8;        // t^2, t^3 and weights, signed
	localparam int C_W       = 21;                   // one packed coordinate, signed
	localparam int V_W       = 3 * C_W;              // a packed vector register
	localparam int P_W       = W_W + C_W;            // full multiplier product
	localparam int R_W       = P_W - FRAC_BITS;      // rounded product
	localparam int A_W       = R_W + 2;              // sum of four rounded products
	localparam int O_W       = 32;                   // output coordinate
	localparam int D_W       = 24;                   // move duration
	localparam int E_W       = 25;                   // elapsed timer
	localparam int S_W       = 16;                   // frame step
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 4;
	localparam int DIVC_W    = $clog2(T_W);

	localparam logic [D_W-1:0] DUR_RESET = D_W'(4096);
	localparam logic [E_W-1:0] E_MAX     = {E_W{1'b1}};
	localparam logic [T_W-1:0] T_CAP     = {T_W{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DURATION   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_START_PT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_START_TAN  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_END_TAN    = CFG_IDX_W'(3);

	// Multiply schedule: two powers of t, then four terms for each of three axes.
	localparam logic [OP_W-1:0] OP_T2    = OP_W'(0);
	localparam logic [OP_W-1:0] OP_T3    = OP_W'(1);
	localparam logic [OP_W-1:0] OP_FIRST = OP_W'(2);
	localparam logic [OP_W-1:0] OP_LAST  = OP_W'(13);

	// Rounding of a fixed-point product: add half an LSB and floor.
	function automatic logic signed [R_W-1:0] fx_round(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] s;
		s = p + P_W'(1 << (FRAC_BITS - 1));
		return R_W'(s >>> FRAC_BITS);
	endfunction

	function automatic logic signed [O_W-1:0] sat32(input logic signed [A_W-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > 64'sh7FFF_FFFF) return {1'b0, {(O_W-1){1'b1}}};
		else if (w < -64'sh8000_0000) return {1'b1, {(O_W-1){1'b0}}};
		else return O_W'(v);
	endfunction

endpackage

// ===== hdl/chps_if.sv =====
// Valid/ready channel interfaces for tick items and position results.
`timescale 1ns / 1ps
interface chps_tick_if;
	logic                                 valid;
	logic                                 ready;
	logic [15:0]                          frame_step;
	logic                                 restart;
	logic signed [20:0]                   goal_x;
	logic signed [20:0]                   goal_y;
	logic signed [20:0]                   goal_z;

	modport source (output valid, frame_step, restart, goal_x, goal_y, goal_z, input ready);
	modport sink   (input valid, frame_step, restart, goal_x, goal_y, goal_z, output ready);
endinterface

interface chps_pos_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [31:0]                   pos_x;
	logic signed [31:0]                   pos_y;
	logic signed [31:0]                   pos_z;
	logic                                 arrived;

	modport source (output valid, pos_x, pos_y, pos_z, arrived, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, arrived, output ready);
endinterface

// ===== hdl/cubic_hermite_path_step.sv =====
// Cubic Hermite path stepper: timer, serial divider and one shared multiplier.
`timescale 1ns / 1ps
// Each tick item advances the elapsed timer, forms t = elapsed/duration with a
// restoring divider (one quotient bit per cycle, skipped when t hits its cap),
// then runs fourteen rounded multiplies through a single 20x21-bit multiplier:
// t^2, t^3 and four weighted terms per axis. The block takes no new item until
// the last result is loaded into the output register; tick.ready is low
// meanwhile. The finished position sits in an output register, so the next item
// is accepted while it waits to be taken. Configuration registers are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while idle,
// as the block itself does not enforce it.
module cubic_hermite_path_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [chps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [chps_pkg::V_W-1:0]       cfg_wdata,
	chps_tick_if.sink                      tick,
	chps_pos_if.source                     pos
);
	import chps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [D_W-1:0]           dur_q;
	logic [V_W-1:0]           start_pt_q;
	logic [V_W-1:0]           start_tan_q;
	logic [V_W-1:0]           end_tan_q;
	logic [E_W-1:0]           elapsed_q;
	logic                     arr_q;
	logic signed [C_W-1:0]    goal_q [3];

	logic [E_W:0]             rem_q;
	logic [T_W-1:0]           quot_q;
	logic [DIVC_W-1:0]        div_cnt_q;
	logic [T_W-1:0]           t_q;
	logic signed [W_W-1:0]    t2_q;
	logic signed [W_W-1:0]    w_q [4];

	logic [OP_W-1:0]          op_q;
	logic                     vld_s1;
	logic [OP_W-1:0]          tag_s1;
	logic signed [P_W-1:0]    prod_s1;
	logic signed [A_W-1:0]    acc_q;
	logic signed [O_W-1:0]    res_q [3];

	logic                     out_valid_q;
	logic signed [O_W-1:0]    out_x_q;
	logic signed [O_W-1:0]    out_y_q;
	logic signed [O_W-1:0]    out_z_q;
	logic                     out_arr_q;

	// Accept-time timer update.
	logic                     accept;
	logic [E_W:0]             e_sum;
	logic [E_W-1:0]           e_new;
	assign accept = tick.valid && tick.ready;
	assign e_sum  = (tick.restart ? '0 : {1'b0, elapsed_q}) + (E_W+1)'(tick.frame_step);
	assign e_new  = e_sum[E_W] ? E_MAX : e_sum[E_W-1:0];

	// Divider step.
	logic                     div_ge;
	logic [E_W:0]             div_sub;
	assign div_ge  = rem_q >= (E_W+1)'(dur_q);
	assign div_sub = div_ge ? rem_q - (E_W+1)'(dur_q) : rem_q;

	// Operand selection for the shared multiplier.
	logic [OP_W-1:0]          ofs;
	logic [1:0]               axis;
	logic [1:0]               term;
	logic signed [W_W-1:0]    mul_a;
	logic signed [C_W-1:0]    mul_b;
	logic [V_W-1:0]           vec_sel;
	logic                     issue;
	assign ofs  = op_q - OP_FIRST;
	assign axis = ofs[3:2];
	assign term = ofs[1:0];
	assign issue = (state_q == ST_MUL) && !(vld_s1 && (op_q <= OP_FIRST));

	always_comb begin
		case (term)
			2'd0:    vec_sel = start_pt_q;
			2'd2:    vec_sel = start_tan_q;
			2'd3:    vec_sel = end_tan_q;
			default: vec_sel = start_pt_q;
		endcase
		case (op_q)
			OP_T2: begin
				mul_a = W_W'(t_q);
				mul_b = C_W'(t_q);
			end
			OP_T3: begin
				mul_a = t2_q;
				mul_b = C_W'(t_q);
			end
			default: begin
				mul_a = w_q[term];
				if (term == 2'd1) mul_b = goal_q[axis];
				else mul_b = vec_sel[axis * C_W +: C_W];
			end
		endcase
	end

	// Writeback of the registered product.
	logic signed [R_W-1:0]    rnd;
	logic signed [W_W-1:0]    t3w;
	logic signed [W_W-1:0]    tw;
	logic [OP_W-1:0]          wofs;
	logic signed [A_W-1:0]    acc_next;
	assign rnd      = fx_round(prod_s1);
	assign t3w      = W_W'(rnd);
	assign tw       = W_W'(t_q);
	assign wofs     = tag_s1 - OP_FIRST;
	assign acc_next = (wofs[1:0] == 2'd0) ? A_W'(rnd) : acc_q + A_W'(rnd);

	logic                     out_free;
	logic                     out_load;
	assign out_free = !out_valid_q || pos.ready;
	assign out_load = (state_q == ST_FIN) && !vld_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dur_q       <= DUR_RESET;
			start_pt_q  <= '0;
			start_tan_q <= '0;
			end_tan_q   <= '0;
			elapsed_q   <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DURATION:  dur_q       <= cfg_wdata[D_W-1:0];
					REG_START_PT:  start_pt_q  <= cfg_wdata;
					REG_START_TAN: start_tan_q <= cfg_wdata;
					REG_END_TAN:   end_tan_q   <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (pos.valid && pos.ready) out_valid_q <= 1'b0;

			vld_s1 <= issue;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						elapsed_q <= e_new;
						op_q      <= OP_T2;
						div_cnt_q <= '0;
						// t saturates once elapsed reaches twice the duration.
						if (e_new >= {dur_q, 1'b0}) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIVC_W'(1);
					if (div_cnt_q == DIVC_W'(T_W - 1)) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (issue) begin
						op_q <= op_q + OP_W'(1);
						if (op_q == OP_LAST) state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q     <= e_new >= E_W'(dur_q);
			goal_q[0] <= tick.goal_x;
			goal_q[1] <= tick.goal_y;
			goal_q[2] <= tick.goal_z;
			rem_q     <= {1'b0, e_new};
			t_q       <= T_CAP;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= {div_sub[E_W-1:0], 1'b0};
			quot_q <= {quot_q[T_W-2:0], div_ge};
			if (div_cnt_q == DIVC_W'(T_W - 1)) t_q <= {quot_q[T_W-2:0], div_ge};
		end
		if (issue) begin
			prod_s1 <= P_W'(mul_a) * P_W'(mul_b);
			tag_s1  <= op_q;
		end
		if (vld_s1) begin
			case (tag_s1)
				OP_T2: t2_q <= W_W'(rnd);
				OP_T3: begin
					w_q[0] <= (t3w <<< 1) - (t2_q <<< 1) - t2_q + W_W'(1 << FRAC_BITS);
					w_q[1] <= (t2_q <<< 1) + t2_q - (t3w <<< 1);
					w_q[2] <= t3w - (t2_q <<< 1) + tw;
					w_q[3] <= t3w - t2_q;
				end
				default: begin
					acc_q <= acc_next;
					if (wofs[1:0] == 2'd3) res_q[wofs[3:2]] <= sat32(acc_next);
				end
			endcase
		end
		if (out_load) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[1];
			out_z_q   <= res_q[2];
			out_arr_q <= arr_q;
		end
	end

	assign tick.ready  = (state_q == ST_IDLE);
	assign pos.valid   = out_valid_q;
	assign pos.pos_x   = out_x_q;
	assign pos.pos_y   = out_y_q;
	assign pos.pos_z   = out_z_q;
	assign pos.arrived = out_arr_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pos.valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV || state_q == ST_MUL))
		else $error("accepted item did not start work");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q <= DIVC_W'(T_W - 1)))
		else $error("divider ran past its last quotient bit");
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && $past(state_q == ST_FIN)) |-> !vld_s1)
		else $error("multiplier still busy late in finish step");
endmodule
